### rtl/core/lpfp_pkg.sv
// ----------------------------------------------------------------------------
// Frame parser package
// Result kinds, the result record passed between the front end, the queue and
// the output stage, and the fixed header layout constants.
// ----------------------------------------------------------------------------
package lpfp_pkg;

  localparam int unsigned HEADER_BYTES      = 6;
  localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd1048576;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  frame_type;
    logic [7:0]  frame_flags;
    logic [31:0] frame_length;
    logic [7:0]  payload_byte;
    logic        frame_last;
  } result_t;

endpackage

### rtl/core/lpfp_front.sv
// ----------------------------------------------------------------------------
// Frame parser front end
// Classifies each accepted byte as header or payload, keeps the frame state
// and produces at most one result record per byte.
// ----------------------------------------------------------------------------
module lpfp_front
  import lpfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  logic [7:0]  in_byte,
  input  logic [31:0] max_payload,
  output logic        res_valid,
  output result_t     res
);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_STUCK   = 2'd2
  } phase_t;

  localparam logic [2:0] HDR_LAST = 3'(HEADER_BYTES - 1);

  phase_t      phase, phase_next;
  logic [2:0]  header_count, header_count_next;
  logic [7:0]  held_type, held_type_next;
  logic [7:0]  held_flags, held_flags_next;
  logic [31:0] held_length, held_length_next;
  logic [31:0] bytes_left, bytes_left_next;
  logic [31:0] full_length;

  assign full_length = {in_byte, held_length[23:0]};

  always_comb begin
    phase_next        = phase;
    header_count_next = header_count;
    held_type_next    = held_type;
    held_flags_next   = held_flags;
    held_length_next  = held_length;
    bytes_left_next   = bytes_left;
    res_valid         = 1'b0;
    res.kind          = KIND_PAYLOAD;
    res.frame_type    = held_type;
    res.frame_flags   = held_flags;
    res.frame_length  = held_length;
    res.payload_byte  = 8'd0;
    res.frame_last    = 1'b0;

    if (take) begin
      unique case (phase)
        PH_STUCK: begin
          // Dropped with no result until reset.
        end
        PH_PAYLOAD: begin
          bytes_left_next  = bytes_left - 32'd1;
          res_valid        = 1'b1;
          res.payload_byte = in_byte;
          res.frame_last   = (bytes_left == 32'd1);
          if (bytes_left == 32'd1) begin
            phase_next        = PH_HEADER;
            header_count_next = 3'd0;
          end
        end
        default: begin
          phase_next        = PH_HEADER;
          header_count_next = header_count + 3'd1;
          unique case (header_count)
            3'd0: held_type_next = in_byte;
            3'd1: held_flags_next = in_byte;
            3'd2: held_length_next = {24'd0, in_byte};
            3'd3: held_length_next[15:8] = in_byte;
            3'd4: held_length_next[23:16] = in_byte;
            default: begin
              // Last header byte: the length is complete and gets checked.
              held_length_next  = full_length;
              header_count_next = 3'd0;
              res_valid         = 1'b1;
              res.frame_length  = full_length;
              if (full_length > max_payload) begin
                res.kind   = KIND_ERROR;
                phase_next = PH_STUCK;
              end else if (full_length == 32'd0) begin
                res.kind       = KIND_EMPTY;
                res.frame_last = 1'b1;
              end else begin
                res_valid       = 1'b0;
                bytes_left_next = full_length;
                phase_next      = PH_PAYLOAD;
              end
            end
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      header_count <= 3'd0;
      held_type    <= 8'd0;
      held_flags   <= 8'd0;
      held_length  <= 32'd0;
      bytes_left   <= 32'd0;
    end else begin
      phase        <= phase_next;
      header_count <= header_count_next;
      held_type    <= held_type_next;
      held_flags   <= held_flags_next;
      held_length  <= held_length_next;
      bytes_left   <= bytes_left_next;
    end
  end

  a_stuck_silent: assert property (@(posedge clk) disable iff (rst)
    phase == PH_STUCK |-> !res_valid)
    else $error("result produced while stuck");

  a_error_sticks: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.kind == KIND_ERROR |=> phase == PH_STUCK)
    else $error("oversize error did not enter stuck phase");

  a_header_bound: assert property (@(posedge clk) disable iff (rst)
    header_count <= HDR_LAST)
    else $error("header byte count out of range");

endmodule

### rtl/core/lpfp_queue.sv
// ----------------------------------------------------------------------------
// Frame parser result queue
// Small synchronous queue of result records between the front end and the
// output stage.
// ----------------------------------------------------------------------------
module lpfp_queue
  import lpfp_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    wr_en,
  input  result_t wr_data,
  input  logic    rd_en,
  output result_t rd_data,
  output logic    full,
  output logic    avail
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  result_t            store [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_wr, do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign avail   = (count != '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && avail;
  assign rd_data = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      store[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !full)
    else $error("write into a full result queue");

endmodule

### rtl/core/lpfp_back.sv
// ----------------------------------------------------------------------------
// Frame parser output stage
// Holds the oldest result record in a register and presents it until popped.
// ----------------------------------------------------------------------------
module lpfp_back
  import lpfp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    q_avail,
  input  result_t q_data,
  output logic    q_rd,
  input  logic    pop,
  output logic    empty,
  output result_t head
);

  logic    head_valid;
  logic    drain;

  assign empty = !head_valid;
  assign drain = pop && head_valid;
  assign q_rd  = q_avail && (!head_valid || drain);

  always_ff @(posedge clk) begin
    if (q_rd) begin
      head <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
    end else if (q_rd) begin
      head_valid <= 1'b1;
    end else if (drain) begin
      head_valid <= 1'b0;
    end
  end

endmodule

### rtl/core/length_prefixed_frame_parser.sv
// ----------------------------------------------------------------------------
// Length-prefixed frame parser
// Splits a byte stream into frames of a six-byte header (type, flags and a
// little-endian 32-bit length) and payload, with at most one result per byte.
// ----------------------------------------------------------------------------
// The edge that takes a byte beat writes its result into the result queue;
//   from there the result moves into the output register once that register
//   is empty or being popped.
// Throughput: one byte beat per cycle, sustained while results are popped at
//   the same rate; the result queue depth sets how long output stalls are hidden.
// Reset: rst clears the header state, the sticky error and the queue, and loads
//   max_payload with 1048576.
module length_prefixed_frame_parser
  import lpfp_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration: maximum accepted payload length.
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  // Input byte beats.
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  // Result beats.
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_kind,
  output logic [7:0]  frame_type,
  output logic [7:0]  frame_flags,
  output logic [31:0] frame_length,
  output logic [7:0]  payload_byte,
  output logic        frame_last
);

  // The configured limit. A length equal to it is still accepted; a frame that
  // is already in its payload keeps running if the limit changes.
  logic [31:0] max_payload;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= MAX_PAYLOAD_RESET;
    end else if (cfg_we) begin
      max_payload <= cfg_wdata;
    end
  end

  logic    take;
  logic    res_valid;
  result_t res;
  logic    q_rd;
  logic    q_avail;
  result_t q_data;
  result_t head;

  // A byte beat is taken whenever the queue has room; the front end decides in
  // the same cycle whether the byte produces a result and writes it straight
  // into the queue.
  assign take = push && !full;

  lpfp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .in_byte     (in_byte),
    .max_payload (max_payload),
    .res_valid   (res_valid),
    .res         (res)
  );

  // The queue decouples the front end from the output side, so input beats
  // keep flowing while a finished result waits to be popped.
  lpfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_valid),
    .wr_data (res),
    .rd_en   (q_rd),
    .rd_data (q_data),
    .full    (full),
    .avail   (q_avail)
  );

  // The output register holds the oldest result and, if one is queued, refills in
  // the cycle it is popped, so back-to-back pops see one result per cycle.
  lpfp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_avail (q_avail),
    .q_data  (q_data),
    .q_rd    (q_rd),
    .pop     (pop),
    .empty   (empty),
    .head    (head)
  );

  assign out_kind     = 2'(head.kind);
  assign frame_type   = head.frame_type;
  assign frame_flags  = head.frame_flags;
  assign frame_length = head.frame_length;
  assign payload_byte = head.payload_byte;
  assign frame_last   = head.frame_last;

endmodule

### sim/length_prefixed_frame_parser_test.sv
// ----------------------------------------------------------------------------
// Length-prefixed frame parser testbench
// Feeds byte beats made of well-formed frames (six-byte header and payload)
// under several maximum payload settings, predicts every result beat in a
// scoreboard and compares each popped result field by field. Both sides idle
// at random. The run ends with an oversize header that makes the error stick.
// ----------------------------------------------------------------------------
module length_prefixed_frame_parser_test;
  import lpfp_pkg::*;

  // Parser position inside the byte stream, as the scoreboard tracks it.
  typedef enum logic [1:0] {
    PARSE_HEADER,
    PARSE_PAYLOAD,
    PARSE_STUCK
  } parse_phase_t;

  // Cycles with no beat on either side before the run is declared hung.
  localparam int unsigned HANG_LIMIT = 2000;
  // Cycles allowed for a byte beat to reach the output after a drain.
  localparam int unsigned SETTLE_CYCLES = 8;

  // The scoreboard mirrors the parser: it follows the header bytes, the
  // payload count and the sticky error, and queues the result beats that each
  // accepted byte beat must produce.
  class frame_scoreboard;
    result_t      pending_results[$];
    int           errors;
    logic [31:0]  max_payload;
    parse_phase_t phase;
    logic [2:0]   header_count;
    logic [7:0]   held_type;
    logic [7:0]   held_flags;
    logic [31:0]  held_length;
    logic [31:0]  bytes_left;

    function new();
      errors       = 0;
      max_payload  = MAX_PAYLOAD_RESET;
      phase        = PARSE_HEADER;
      header_count = '0;
      held_type    = '0;
      held_flags   = '0;
      held_length  = '0;
      bytes_left   = '0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void set_limit(logic [31:0] value);
      max_payload = value;
    endfunction

    function void queue_result(kind_t kind, logic [7:0] data, logic last);
      result_t r;
      r.kind         = kind;
      r.frame_type   = held_type;
      r.frame_flags  = held_flags;
      r.frame_length = held_length;
      r.payload_byte = data;
      r.frame_last   = last;
      pending_results = {pending_results, r};
    endfunction

    // Advances the parser state by one accepted byte beat.
    function void parse_byte(logic [7:0] b);
      if (phase == PARSE_STUCK) return;
      if (phase == PARSE_PAYLOAD) begin
        bytes_left = bytes_left - 1;
        if (bytes_left == 0) begin
          phase        = PARSE_HEADER;
          header_count = '0;
          queue_result(KIND_PAYLOAD, b, 1'b1);
        end else begin
          queue_result(KIND_PAYLOAD, b, 1'b0);
        end
        return;
      end
      // The length arrives least significant byte first.
      case (header_count)
        3'd0: held_type = b;
        3'd1: held_flags = b;
        3'd2: held_length = {24'd0, b};
        default: held_length |= 32'(b) << (8 * (header_count - 3'd2));
      endcase
      header_count = header_count + 3'd1;
      if (header_count < HEADER_BYTES) return;
      header_count = '0;
      if (held_length > max_payload) begin
        phase = PARSE_STUCK;
        queue_result(KIND_ERROR, 8'h00, 1'b0);
      end else if (held_length == 0) begin
        queue_result(KIND_EMPTY, 8'h00, 1'b1);
      end else begin
        bytes_left = held_length;
        phase      = PARSE_PAYLOAD;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: out_kind %0d frame_type %0h",
               got.kind, got.frame_type);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.kind !== want.kind) begin
        $error("out_kind: expected %0d, got %0d", want.kind, got.kind);
        errors++;
      end
      if (got.frame_type !== want.frame_type) begin
        $error("frame_type: expected %0h, got %0h", want.frame_type, got.frame_type);
        errors++;
      end
      if (got.frame_flags !== want.frame_flags) begin
        $error("frame_flags: expected %0h, got %0h", want.frame_flags, got.frame_flags);
        errors++;
      end
      if (got.frame_length !== want.frame_length) begin
        $error("frame_length: expected %0h, got %0h", want.frame_length, got.frame_length);
        errors++;
      end
      if (got.payload_byte !== want.payload_byte) begin
        $error("payload_byte: expected %0h, got %0h", want.payload_byte, got.payload_byte);
        errors++;
      end
      if (got.frame_last !== want.frame_last) begin
        $error("frame_last: expected %0b, got %0b", want.frame_last, got.frame_last);
        errors++;
      end
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        push      = 1'b0;
  logic        full;
  logic [7:0]  in_byte   = '0;
  logic        empty;
  logic        pop       = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  frame_type;
  logic [7:0]  frame_flags;
  logic [31:0] frame_length;
  logic [7:0]  payload_byte;
  logic        frame_last;

  // When set, neither side inserts idle cycles.
  bit              no_idle = 1'b0;
  int unsigned     hang_count = 0;
  frame_scoreboard sb = new();

  length_prefixed_frame_parser u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .push         (push),
    .full         (full),
    .in_byte      (in_byte),
    .empty        (empty),
    .pop          (pop),
    .out_kind     (out_kind),
    .frame_type   (frame_type),
    .frame_flags  (frame_flags),
    .frame_length (frame_length),
    .payload_byte (payload_byte),
    .frame_last   (frame_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Monitor, result side driver and hang watchdog. Every signal is read here
  // at the clock edge, before the nonblocking updates of that edge land, so
  // both handshakes are seen exactly as the parser sees them.
  always @(posedge clk) begin : monitor
    result_t got;
    if (!rst) begin
      if (push && !full) sb.parse_byte(in_byte);
      if (pop && !empty) begin
        got = '{kind_t'(out_kind), frame_type, frame_flags, frame_length,
                payload_byte, frame_last};
        sb.check_result(got);
      end
      if ((push && !full) || (pop && !empty)) begin
        hang_count = 0;
      end else begin
        hang_count++;
        if (hang_count >= HANG_LIMIT) begin
          $display("Testbench completed WITH ERRORS");
          $finish;
        end
      end
    end
    // The result side stalls on about a third of the cycles.
    pop <= no_idle || ($urandom_range(99) >= 33);
  end

  // Sends one byte beat, with random idle cycles ahead of it. push is left
  // high on return so that back-to-back beats keep it asserted.
  task automatic send_byte(input logic [7:0] value);
    while (!no_idle && $urandom_range(99) < 33) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_byte <= value;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic send_header(input logic [7:0] ftype, input logic [7:0] flags,
                             input logic [31:0] len);
    send_byte(ftype);
    send_byte(flags);
    for (int k = 0; k < 4; k++) send_byte(len[8*k +: 8]);
  endtask

  // A negative fill picks each payload byte at random.
  task automatic send_frame(input logic [7:0] ftype, input logic [7:0] flags,
                            input logic [31:0] len, input int fill);
    send_header(ftype, flags, len);
    for (int i = 0; i < int'(len); i++) begin
      send_byte(fill < 0 ? 8'($urandom) : 8'(fill));
    end
  endtask

  // The register is only written while the parser is quiet: every predicted
  // result must have been popped, and since header bytes produce nothing the
  // last few beats are given time to work through the pipeline as well.
  task automatic set_max_payload(input logic [31:0] value);
    push <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_limit(value);
  endtask

  // One random section: frames of random type, flags and content whose
  // lengths never exceed the current limit. Most lengths are short, a few
  // reach 48 bytes, and about one frame in seven is empty.
  task automatic run_section(input logic [31:0] limit, input int byte_budget);
    int          sent;
    int          cap;
    logic [31:0] len;
    sent = 0;
    set_max_payload(limit);
    while (sent < byte_budget) begin
      cap = (limit > 12) ? 12 : int'(limit);
      if (limit >= 48 && $urandom_range(19) == 0) cap = 48;
      if (cap == 0 || $urandom_range(99) < 15) len = 0;
      else len = $urandom_range(cap, 1);
      send_frame(8'($urandom), 8'($urandom), len, -1);
      sent += HEADER_BYTES + int'(len);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed frames under the reset limit: an all-zero empty frame and a
    // one-byte frame with every type, flags and payload bit set.
    send_frame(8'h00, 8'h00, 32'd0, 0);
    send_frame(8'hFF, 8'hFF, 32'd1, 8'hFF);
    // A length equal to the limit is accepted, down to a limit of zero.
    set_max_payload(32'd1);
    send_frame(8'h5A, 8'hA5, 32'd1, 8'h00);
    set_max_payload(32'd0);
    send_frame(8'hA5, 8'h5A, 32'd0, 0);

    // Random sections across limits from zero to the top of the range. The
    // reset-value section runs with no idling at all on either side.
    run_section(32'hFFFF_FFFF, 110);
    run_section(32'd0, 110);
    run_section(32'($urandom_range(16, 1)), 110);
    no_idle = 1'b1;
    run_section(MAX_PAYLOAD_RESET, 110);
    no_idle = 1'b0;
    run_section($urandom() | 32'h0001_0000, 110);
    run_section(32'($urandom_range(4, 1)), 110);

    // Closing section: a limit one below the largest length, regular frames,
    // then a header with the largest length. The error result must come out
    // once, after which every byte beat is dropped without a result.
    run_section(32'hFFFF_FFFE, 12);
    send_header(8'($urandom), 8'($urandom), 32'hFFFF_FFFF);
    repeat (24) send_byte(8'($urandom));

    push <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/lpfp_pkg.sv
rtl/core/lpfp_front.sv
rtl/core/lpfp_queue.sv
rtl/core/lpfp_back.sv
rtl/core/length_prefixed_frame_parser.sv
sim/length_prefixed_frame_parser_test.sv
